@@ hw/rtl/wms_pkg.sv @@
`timescale 1ns / 1ps
package wms_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int LEN_W      = 7;
   localparam int POS_W      = 11;
   localparam int CNT_W      = 10;
   localparam int FEAT_W     = 20;
   localparam int NUM_W      = 48;
   localparam int DEN_W      = 18;
   localparam int RES_W      = 34;

   localparam logic [POS_W-1:0] POS_MAX   = '1;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      REG_LENGTH  = 2'd0,
      REG_OVERLAP = 2'd1,
      REG_MODE    = 2'd2
   } reg_index_type;

   typedef enum logic {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic [7:0] sample;
      logic       column_start;
   } req_type;

   typedef struct packed {
      logic signed [FEAT_W-1:0] feature_a;
      logic signed [FEAT_W-1:0] feature_b;
      logic [CNT_W-1:0]         window_index;
   } rsp_type;

   typedef struct packed {
      logic             start;
      unit_op_type      op;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } unit_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [RES_W-1:0] result;
   } unit_stat_type;

endpackage

@@ hw/rtl/wms_iter_unit.sv @@
`timescale 1ns / 1ps
// Shared restoring divider / integer square root, one result bit per cycle.
module wms_iter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  wms_pkg::unit_cmd_type cmd,
   output wms_pkg::unit_stat_type stat
);
   import wms_pkg::*;

   localparam int W = 28;

   logic             busy_ff;
   logic             done_ff;
   unit_op_type      op_ff;
   logic [5:0]       cnt_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     rem_in;
   logic [NUM_W-1:0] work_ff;
   logic [RES_W-1:0] res_ff;
   logic [DEN_W-1:0] den_ff;

   logic [W-1:0] cand;
   logic [W-1:0] trial;
   logic [W:0]   diff;
   logic         ge;
   logic         last;

   always_comb begin
      if (op_ff == OP_DIV) begin
         cand  = {rem_ff[W-2:0], work_ff[NUM_W-1]};
         trial = {{(W-DEN_W){1'b0}}, den_ff};
      end else begin
         cand  = {rem_ff[W-3:0], work_ff[NUM_W-1:NUM_W-2]};
         trial = {2'b00, res_ff[23:0], 2'b01};
      end
      diff   = {1'b0, cand} - {1'b0, trial};
      ge     = ~diff[W];
      rem_in = ge ? diff[W-1:0] : cand;
      last   = (op_ff == OP_DIV) ? (cnt_ff == 6'd33) : (cnt_ff == 6'd23);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff & last;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= cmd.op;
         den_ff <= cmd.den;
         cnt_ff <= '0;
         rem_ff <= '0;
         res_ff <= '0;
         if (cmd.op == OP_DIV) begin
            work_ff <= {cmd.num[RES_W-1:0], {(NUM_W-RES_W){1'b0}}};
         end else begin
            work_ff <= cmd.num;
         end
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         rem_ff <= rem_in;
         res_ff <= {res_ff[RES_W-2:0], ge};
         if (op_ff == OP_DIV) begin
            work_ff <= {work_ff[NUM_W-2:0], 1'b0};
         end else begin
            work_ff <= {work_ff[NUM_W-3:0], 2'b00};
         end
      end
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign stat.result = res_ff;

endmodule

@@ hw/rtl/windowed_mean_std_or_line_fit.sv @@
`timescale 1ns / 1ps
// Sliding-window feature extractor for one image column. Each accepted word
// carries one 8-bit sample; column_start restarts window numbering. A sample
// that does not close a window is taken and req_ready stays high.
// A sample that closes a window of L samples holds req_ready low while the
// window is walked out of the 64-entry sample memory, the multiply steps (MA,
// MB, and MC in line-fit mode) run on one shared multiplier, and the shared
// divide/square-root unit runs its operations. The result sits in an output
// register; the next sample is taken while it waits, but the following
// window holds in its last step until the earlier word leaves. Configuration
// writes are taken at any time (csr_ready is always high) and must be made
// while the block is idle; length and mode are sampled when a window closes.
module windowed_mean_std_or_line_fit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wms_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wms_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [6:0]            csr_data
);
   import wms_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_WALK = 9'b000000010,
      ST_MA   = 9'b000000100,
      ST_MB   = 9'b000001000,
      ST_MC   = 9'b000010000,
      ST_DIVA = 9'b000100000,
      ST_SQRT = 9'b001000000,
      ST_DIVB = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [LEN_W-1:0] length_ff;
   logic [5:0]       overlap_ff;
   logic             mode_ff;

   // column schedule
   logic [POS_W-1:0]  position_ff;
   logic [POS_W-1:0]  next_end_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] wptr_ff;

   // per-window working registers
   logic [LEN_W-1:0]  len_ff;
   logic              wmode_ff;
   logic [CNT_W-1:0]  widx_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [LEN_W-1:0]  rd_cnt_ff;
   logic [LEN_W-1:0]  rcv_cnt_ff;
   logic [7:0]        rdata_ff;
   logic              rvld_ff;
   logic [13:0]       s_ff;
   logic [21:0]       q_ff;
   logic [19:0]       acc_ff;
   logic [28:0]       ta_ff;
   logic [28:0]       tb_ff;
   logic [17:0]       tc_ff;
   logic [23:0]       root_ff;
   logic signed [FEAT_W-1:0] fa_ff;
   logic signed [FEAT_W-1:0] fb_ff;
   logic              go_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic [7:0] mem [MAX_WINDOW];

   unit_cmd_type  cmd;
   unit_stat_type stat;

   wms_iter_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // ---------------- input side: schedule decision at accept -----------------
   logic             accept;
   logic [LEN_W-1:0] len_clamp;
   logic [LEN_W-1:0] step;
   logic [POS_W-1:0] pos_cur;
   logic [POS_W-1:0] end_cur;
   logic [CNT_W-1:0] count_cur;
   logic             fire;

   always_comb begin
      if (length_ff < LEN_W'(2)) begin
         len_clamp = LEN_W'(2);
      end else if (length_ff > LEN_W'(MAX_WINDOW)) begin
         len_clamp = LEN_W'(MAX_WINDOW);
      end else begin
         len_clamp = length_ff;
      end
      step      = (len_clamp > {1'b0, overlap_ff}) ? len_clamp - {1'b0, overlap_ff}
                                                   : LEN_W'(1);
      pos_cur   = req_data.column_start ? '0 : position_ff;
      count_cur = req_data.column_start ? '0 : count_ff;
      end_cur   = (pos_cur == '0) ? POS_W'(len_clamp) : next_end_ff;
      fire      = (pos_cur != POS_MAX) && ((pos_cur + POS_W'(1)) == end_cur);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= LEN_W'(16);
         overlap_ff <= 6'd8;
         mode_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LENGTH:  length_ff  <= csr_data;
            REG_OVERLAP: overlap_ff <= csr_data[5:0];
            REG_MODE:    mode_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         next_end_ff <= '0;
         count_ff    <= '0;
         wptr_ff     <= '0;
      end else if (accept) begin
         wptr_ff <= wptr_ff + ADDR_W'(1);
         if (pos_cur != POS_MAX) begin
            position_ff <= pos_cur + POS_W'(1);
         end else begin
            position_ff <= pos_cur;
         end
         if (fire) begin
            next_end_ff <= end_cur + POS_W'(step);
            count_ff    <= (count_cur != COUNT_MAX) ? count_cur + CNT_W'(1) : count_cur;
         end else begin
            next_end_ff <= end_cur;
            count_ff    <= count_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && fire) begin
         len_ff   <= len_clamp;
         wmode_ff <= mode_ff;
         widx_ff  <= count_cur;
         base_ff  <= wptr_ff + ADDR_W'(1) - len_clamp[ADDR_W-1:0];
      end
   end

   // ---------------- sample memory -------------------------------------------
   logic issue;
   assign issue = (state_ff == ST_WALK) && (rd_cnt_ff < len_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wptr_ff] <= req_data.sample;
      end
      if (issue) begin
         rdata_ff <= mem[base_ff + rd_cnt_ff[ADDR_W-1:0]];
      end
   end

   // ---------------- window walk: sum, sum of squares, running prefix sum ----
   // sum(i*y) over positions 1..L equals (L+1)*S - acc, acc being the sum of
   // the prefix sums, so no index multiply is needed per sample.
   logic [13:0] s_new;
   assign s_new = s_ff + 14'(rdata_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rvld_ff <= 1'b0;
      end else begin
         rvld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && fire) begin
         rd_cnt_ff  <= '0;
         rcv_cnt_ff <= '0;
         s_ff       <= '0;
         q_ff       <= '0;
         acc_ff     <= '0;
      end else begin
         if (issue) begin
            rd_cnt_ff <= rd_cnt_ff + LEN_W'(1);
         end
         if (rvld_ff) begin
            rcv_cnt_ff <= rcv_cnt_ff + LEN_W'(1);
            s_ff       <= s_new;
            q_ff       <= q_ff + 22'(rdata_ff * rdata_ff);
            acc_ff     <= acc_ff + 20'(s_new);
         end
      end
   end

   // ---------------- shared multiplier ---------------------------------------
   logic [21:0] mul_a;
   logic [13:0] mul_b;
   logic [35:0] prod;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MA: begin
            mul_a = wmode_ff ? 22'(s_ff) : q_ff;
            mul_b = wmode_ff ? 14'(len_ff + LEN_W'(1)) : 14'(len_ff);
         end
         ST_MB: begin
            mul_a = wmode_ff ? 22'(len_ff) : 22'(s_ff);
            mul_b = wmode_ff ? 14'(len_ff) : s_ff;
         end
         ST_MC: begin
            mul_a = 22'(tb_ff[12:0] - 13'd1);
            mul_b = 14'(len_ff);
         end
         default: ;
      endcase
      prod = 36'(mul_a) * 36'(mul_b);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_MA: ta_ff <= prod[28:0];
         ST_MB: tb_ff <= wmode_ff ? prod[28:0] : ta_ff - prod[28:0];
         ST_MC: tc_ff <= prod[17:0];
         default: ;
      endcase
   end

   // ---------------- divide / root operands ----------------------------------
   // slope numerator 1536*((L+1)S - 2acc), intercept 512*(3acc - (L+2)S)
   logic signed [23:0] x_val;
   logic signed [23:0] y_val;
   logic [22:0]        x_mag;
   logic [22:0]        y_mag;
   logic [12:0]        den_b;

   always_comb begin
      x_val = $signed({3'b000, ta_ff[20:0]}) - $signed({3'b000, acc_ff, 1'b0});
      y_val = $signed({2'b00, acc_ff, 1'b0}) + $signed({4'b0000, acc_ff})
              - $signed({3'b000, ta_ff[20:0]}) - $signed({10'd0, s_ff});
      x_mag = x_val[23] ? 23'(-x_val) : x_val[22:0];
      y_mag = y_val[23] ? 23'(-y_val) : y_val[22:0];
      den_b = tb_ff[12:0] - 13'(len_ff);
   end

   always_comb begin
      cmd.start = go_ff;
      cmd.op    = OP_DIV;
      cmd.num   = '0;
      cmd.den   = '0;
      case (state_ff)
         ST_DIVA: begin
            if (wmode_ff) begin
               cmd.num = NUM_W'({x_mag, 10'd0}) + NUM_W'({x_mag, 9'd0})
                         + NUM_W'(tc_ff[17:1]);
               cmd.den = tc_ff;
            end else begin
               cmd.num = NUM_W'({s_ff, 8'd0}) + NUM_W'(len_ff[LEN_W-1:1]);
               cmd.den = DEN_W'(len_ff);
            end
         end
         ST_SQRT: begin
            cmd.op  = OP_SQRT;
            cmd.num = {1'b0, tb_ff, 18'd0};
         end
         ST_DIVB: begin
            if (wmode_ff) begin
               cmd.num = NUM_W'({y_mag, 9'd0}) + NUM_W'(den_b[12:1]);
               cmd.den = DEN_W'(den_b);
            end else begin
               cmd.num = NUM_W'(root_ff) + NUM_W'(len_ff);
               cmd.den = DEN_W'({len_ff, 1'b0});
            end
         end
         default: ;
      endcase
   end

   function automatic logic signed [FEAT_W-1:0] saturate(input logic neg,
                                                         input logic [RES_W-1:0] mag);
      logic signed [FEAT_W-1:0] v;
      if (!neg) begin
         v = (mag > RES_W'(524287)) ? FEAT_W'(524287) : $signed(mag[FEAT_W-1:0]);
      end else begin
         v = (mag > RES_W'(524288)) ? $signed({1'b1, {(FEAT_W-1){1'b0}}})
                                    : $signed(-mag[FEAT_W-1:0]);
      end
      return v;
   endfunction

   always_ff @(posedge clock) begin
      if (stat.done) begin
         case (state_ff)
            ST_DIVA: fa_ff   <= saturate(wmode_ff & x_val[23], stat.result);
            ST_SQRT: root_ff <= stat.result[23:0];
            ST_DIVB: fb_ff   <= saturate(wmode_ff & y_val[23], stat.result);
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ------------------------------------------------
   logic out_free;
   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && fire) state_in = ST_WALK;
         ST_WALK: if (rvld_ff && (rcv_cnt_ff == len_ff - LEN_W'(1))) state_in = ST_MA;
         ST_MA:   state_in = ST_MB;
         ST_MB:   state_in = wmode_ff ? ST_MC : ST_DIVA;
         ST_MC:   state_in = ST_DIVA;
         ST_DIVA: if (stat.done) state_in = wmode_ff ? ST_DIVB : ST_SQRT;
         ST_SQRT: if (stat.done) state_in = ST_DIVB;
         ST_DIVB: if (stat.done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= (state_in != state_ff) &&
                     ((state_in == ST_DIVA) || (state_in == ST_SQRT) ||
                      (state_in == ST_DIVB));
      end
   end

   // ---------------- output register -----------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_ff.feature_a    <= fa_ff;
         rsp_ff.feature_b    <= fb_ff;
         rsp_ff.window_index <= widx_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !stat.busy) else $error("unit started while busy");
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == ST_DIVA || state_ff == ST_SQRT || state_ff == ST_DIVB))
      else $error("unit result in wrong state");
   a_fire_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && fire) |=> !req_ready) else $error("input taken during window");
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid) else $error("result lost");
`endif

endmodule
